// ----- sv/prng_matrix_cell_generator_unit_defines.svh -----
// Assertion macros used by the checker file.
`ifndef PRNG_MATRIX_CELL_GENERATOR_UNIT_DEFINES_SVH
`define PRNG_MATRIX_CELL_GENERATOR_UNIT_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define PRMCG_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define PRMCG_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/prmcg_pkg.sv -----
// Shared constants and types of the matrix cell generator.
package prmcg_pkg;

    localparam int MATRIX_DIM  = 64;
    localparam int IDX_W       = (MATRIX_DIM > 1) ? $clog2(MATRIX_DIM) : 1;
    localparam int FIELD_W     = 6;
    localparam int CFG_IDX_W   = 8;
    localparam int SEED_WORDS  = 4;
    localparam int QUEUE_DEPTH = 2;

    localparam int ROT_OUT = 23;
    localparam int SHIFT_T = 17;
    localparam int ROT_S3  = 45;

    // 1e6 = 15625 * 2^6; 15625 is 1.907 * 2^13, so the exponent grows by 19
    localparam logic [13:0] SCALE_INT = 14'd15625;
    localparam logic [10:0] EXP_ADJ   = 11'd19;
    localparam logic [10:0] EXP_QBASE = 11'd1022;

    localparam logic [CFG_IDX_W-1:0] CFG_SEED_WORD0 = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SEED_WORD3 = 8'd3;

    typedef struct packed {
        logic [FIELD_W-1:0] row;
        logic [FIELD_W-1:0] column;
        logic               last;
    } pos_t;

    typedef struct packed {
        logic [63:0] data;
        pos_t        pos;
    } cell_t;

    function automatic logic [63:0] rotl64(input logic [63:0] x, input int k);
        return (x << k) | (x >> (64 - k));
    endfunction

endpackage

// ----- sv/prmcg_fifo.sv -----
// Small register queue of cell words.
module prmcg_fifo
    import prmcg_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  wr_en,
    input  cell_t wr_data,
    output logic  full,
    input  logic  rd_en,
    output cell_t rd_data,
    output logic  empty
);
    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    cell_t            mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_wr, do_rd;

    assign full    = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// ----- sv/prmcg_front.sv -----
// Front end: seed registers, xoshiro256++ generator and cell position counters.
module prmcg_front
    import prmcg_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [63:0]          cfg_data,
    input  logic                 take,
    input  logic                 restart,
    output cell_t                item
);
    localparam logic [IDX_W-1:0] DIM_LAST = IDX_W'(MATRIX_DIM - 1);

    logic [63:0]      seed_reg [SEED_WORDS];
    logic [63:0]      gen_reg  [SEED_WORDS];
    logic [63:0]      gen_next [SEED_WORDS];
    logic [63:0]      s        [SEED_WORDS];
    logic [IDX_W-1:0] row_reg, row_next, col_reg, col_next, cur_row, cur_col;
    logic [63:0]      res, t, x2, x3;
    logic [FIELD_W+IDX_W-1:0] row_ext, col_ext;

    always_comb
    begin
        for (int i = 0; i < SEED_WORDS; i++)
        begin
            s[i] = restart ? seed_reg[i] : gen_reg[i];
        end
        cur_row = restart ? '0 : row_reg;
        cur_col = restart ? '0 : col_reg;

        res = rotl64(s[0] + s[3], ROT_OUT) + s[0];
        t   = s[1] << SHIFT_T;
        x2  = s[2] ^ s[0];
        x3  = s[3] ^ s[1];
        gen_next[1] = s[1] ^ x2;
        gen_next[0] = s[0] ^ x3;
        gen_next[2] = x2 ^ t;
        gen_next[3] = rotl64(x3, ROT_S3);

        if (cur_col == DIM_LAST)
        begin
            col_next = '0;
            row_next = (cur_row == DIM_LAST) ? '0 : cur_row + 1'b1;
        end
        else
        begin
            col_next = cur_col + 1'b1;
            row_next = cur_row;
        end

        row_ext = {{FIELD_W{1'b0}}, cur_row};
        col_ext = {{FIELD_W{1'b0}}, cur_col};
        item.data       = {32'd0, res[31:0]};
        item.pos.row    = row_ext[FIELD_W-1:0];
        item.pos.column = col_ext[FIELD_W-1:0];
        item.pos.last   = (cur_row == DIM_LAST) && (cur_col == DIM_LAST);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SEED_WORDS; i++)
            begin
                seed_reg[i] <= '0;
                gen_reg[i]  <= '0;
            end
            row_reg <= '0;
            col_reg <= '0;
        end
        else
        begin
            if (cfg_valid && (cfg_index <= CFG_SEED_WORD3) && (cfg_index >= CFG_SEED_WORD0))
            begin
                seed_reg[cfg_index[1:0]] <= cfg_data;
            end
            if (take)
            begin
                for (int i = 0; i < SEED_WORDS; i++)
                begin
                    gen_reg[i] <= gen_next[i];
                end
                row_reg <= row_next;
                col_reg <= col_next;
            end
        end
    end

endmodule

// ----- sv/prmcg_back.sv -----
// Back end: three-stage pipeline from 32-bit sample to scaled double.
module prmcg_back
    import prmcg_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    input  cell_t in_word,
    output logic  in_pop,
    input  logic  out_full,
    output logic  out_push,
    output cell_t out_word
);
    // stage 1: normalize; L/(2^32-1) has the bits of L repeating forever
    logic        v1_reg, v2_reg, v3_reg;
    logic        zero1_reg, zero2_reg, zero3_reg;
    logic [31:0] r1_reg;
    logic [4:0]  z1_reg;
    logic [52:0] m2_reg;
    logic [10:0] eb2_reg, eb3_reg;
    logic [66:0] p3_reg;
    pos_t        pos1_reg, pos2_reg, pos3_reg;
    logic        rdy1, rdy2, rdy3;

    logic [31:0] lv, nx;
    logic [4:0]  zc;
    logic [63:0] rot;
    logic [53:0] sum2;
    logic [66:0] p_next;
    logic        hi, rnd, sticky, up;
    logic [52:0] sig;
    logic [53:0] s3;
    logic [10:0] eb_out;

    assign rdy3   = !v3_reg || !out_full;
    assign rdy2   = !v2_reg || rdy3;
    assign rdy1   = !v1_reg || rdy2;
    assign in_pop = in_valid && rdy1;
    assign out_push = v3_reg && !out_full;

    always_comb
    begin
        lv = in_word.data[31:0];
        nx = lv;
        zc = '0;
        if (nx[31:16] == '0) begin nx = nx << 16; zc[4] = 1'b1; end
        if (nx[31:24] == '0) begin nx = nx << 8;  zc[3] = 1'b1; end
        if (nx[31:28] == '0) begin nx = nx << 4;  zc[2] = 1'b1; end
        if (nx[31:30] == '0) begin nx = nx << 2;  zc[1] = 1'b1; end
        if (nx[31] == 1'b0)  begin zc[0] = 1'b1; end
        rot = {lv, lv} << zc;

        // 53 bits plus round bit; the tail is never zero so no tie
        sum2   = {1'b0, r1_reg, r1_reg[31:11]} + 54'(r1_reg[10]);
        p_next = m2_reg * SCALE_INT;

        hi     = p3_reg[66];
        sig    = hi ? p3_reg[66:14] : p3_reg[65:13];
        rnd    = hi ? p3_reg[13] : p3_reg[12];
        sticky = hi ? (|p3_reg[12:0]) : (|p3_reg[11:0]);
        up     = rnd && (sticky || sig[0]);
        s3     = {1'b0, sig} + 54'(up);
        eb_out = eb3_reg + EXP_ADJ + 11'(hi) + 11'(s3[53]);
        out_word.pos  = pos3_reg;
        out_word.data = zero3_reg ? 64'd0
                      : {1'b0, eb_out, (s3[53] ? 52'd0 : s3[51:0])};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (rdy1) v1_reg <= in_valid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1)
        begin
            zero1_reg <= (lv == '0);
            z1_reg    <= zc;
            r1_reg    <= rot[63:32];
            pos1_reg  <= in_word.pos;
        end
        if (rdy2)
        begin
            zero2_reg <= zero1_reg;
            m2_reg    <= sum2[53] ? {1'b1, 52'd0} : sum2[52:0];
            eb2_reg   <= EXP_QBASE - {6'd0, z1_reg} + 11'(sum2[53]);
            pos2_reg  <= pos1_reg;
        end
        if (rdy3)
        begin
            zero3_reg <= zero2_reg;
            p3_reg    <= p_next;
            eb3_reg   <= eb2_reg;
            pos3_reg  <= pos2_reg;
        end
    end

endmodule

// ----- sv/prng_matrix_cell_generator_unit.sv -----
// Matrix cell generator, top level.
// Produces the cells of a 64 x 64 matrix in row-major order, one cell per word
// pushed: a xoshiro256++ step, the low 32 bits scaled to [0, 1e6] as an IEEE
// double, with row, column and a last-cell flag. Seeds written over the config
// port take effect at the next word with restart set. Throughput is one cell
// per clock while the result side keeps popping; the generator step is
// combinational in the front end, then a word passes a two-entry queue, a
// three-stage float pipeline (normalize, round, multiply and pack) and a
// two-entry result queue. cfg_ready is always high.
module prng_matrix_cell_generator_unit
    import prmcg_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 full,
    input  logic                 restart,
    output logic                 empty,
    input  logic                 pop,
    output logic [63:0]          cell_bits,
    output logic [FIELD_W-1:0]   row,
    output logic [FIELD_W-1:0]   column,
    output logic                 last_cell,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [63:0]          cfg_data
);
    cell_t front_word, q_word, back_word, res_word;
    logic  take, q_empty, q_pop, out_full, out_push;

    assign cfg_ready = 1'b1;
    assign take      = push && !full;

    prmcg_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .take      (take),
        .restart   (restart),
        .item      (front_word)
    );

    prmcg_fifo u_mid_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (push),
        .wr_data (front_word),
        .full    (full),
        .rd_en   (q_pop),
        .rd_data (q_word),
        .empty   (q_empty)
    );

    prmcg_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (!q_empty),
        .in_word  (q_word),
        .in_pop   (q_pop),
        .out_full (out_full),
        .out_push (out_push),
        .out_word (back_word)
    );

    prmcg_fifo u_out_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (out_push),
        .wr_data (back_word),
        .full    (out_full),
        .rd_en   (pop),
        .rd_data (res_word),
        .empty   (empty)
    );

    assign cell_bits = res_word.data;
    assign row       = res_word.pos.row;
    assign column    = res_word.pos.column;
    assign last_cell = res_word.pos.last;

endmodule

// ----- sv/prmcg_checker.sv -----
// Port-level checks of the matrix cell generator, bound to the top level.
`include "prng_matrix_cell_generator_unit_defines.svh"
module prmcg_checker
    import prmcg_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 push,
    input logic                 full,
    input logic                 restart,
    input logic                 empty,
    input logic                 pop,
    input logic [63:0]          cell_bits,
    input logic [FIELD_W-1:0]   row,
    input logic [FIELD_W-1:0]   column,
    input logic                 last_cell,
    input logic                 cfg_valid,
    input logic                 cfg_ready,
    input logic [CFG_IDX_W-1:0] cfg_index,
    input logic [63:0]          cfg_data
);
    localparam logic [FIELD_W-1:0] FLD_LAST = FIELD_W'(MATRIX_DIM - 1);

    `PRMCG_ASSERT_NEXT(a_hold, (!empty && !pop), (!empty && $stable(cell_bits)), "word dropped")
    `PRMCG_ASSERT_NOW(a_last, (!empty && last_cell), (row == FLD_LAST && column == FLD_LAST), "last cell misplaced")
    `PRMCG_ASSERT_NOW(a_sign, (!empty), (!cell_bits[63]), "negative cell")
    `PRMCG_ASSERT_NOW(a_range, (!empty), (cell_bits[62:52] <= 11'd1042), "cell above 1e6")

endmodule

bind prng_matrix_cell_generator_unit prmcg_checker u_prmcg_checker (.*);

// ----- sim/prng_matrix_cell_generator_unit_test.sv -----
// Self-checking testbench for the seeded matrix cell generator.
module prng_matrix_cell_generator_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import prmcg_pkg::*;

    localparam int CELLS     = MATRIX_DIM * MATRIX_DIM;
    localparam int LIMIT     = 600000;

    typedef struct {
        bit [63:0]        bits;
        bit [FIELD_W-1:0] row;
        bit [FIELD_W-1:0] column;
        bit               last;
    } cell_exp_t;

    typedef struct {
        bit        known;
        cell_exp_t want;
    } typed_exp_t;

    // directed row: seed set, restart flag, optional typed expectation
    typedef struct {
        int         seed_set;
        bit         restart;
        typed_exp_t typed;
    } dir_row_t;

    logic                 clk;
    logic                 rst_n;
    logic                 push;
    logic                 full;
    logic                 restart;
    logic                 empty;
    logic                 pop;
    logic [63:0]          cell_bits;
    logic [FIELD_W-1:0]   row;
    logic [FIELD_W-1:0]   column;
    logic                 last_cell;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [63:0]          cfg_data;

    bit [63:0]  seed_copy [SEED_WORDS];
    bit [63:0]  gen_copy [SEED_WORDS];
    int         next_pos;
    cell_exp_t  cell_q [$];
    typed_exp_t typed_q [$];
    int         errors;
    int         cycles;
    bit         no_stall;

    prng_matrix_cell_generator_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .restart   (restart),
        .empty     (empty),
        .pop       (pop),
        .cell_bits (cell_bits),
        .row       (row),
        .column    (column),
        .last_cell (last_cell),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    // one xoshiro256++ step plus the float scaling
    function automatic cell_exp_t next_cell(input bit rs);
        cell_exp_t c;
        bit [63:0] sum;
        bit [63:0] res;
        bit [63:0] t;
        bit [63:0] low;
        real       v;
        int        p;
        if (rs)
        begin
            gen_copy = seed_copy;
            next_pos = 0;
        end
        p   = next_pos;
        sum = gen_copy[0] + gen_copy[3];
        res = ((sum << ROT_OUT) | (sum >> (64 - ROT_OUT))) + gen_copy[0];
        t   = gen_copy[1] << SHIFT_T;
        gen_copy[2] ^= gen_copy[0];
        gen_copy[3] ^= gen_copy[1];
        gen_copy[1] ^= gen_copy[2];
        gen_copy[0] ^= gen_copy[3];
        gen_copy[2] ^= t;
        gen_copy[3] = (gen_copy[3] << ROT_S3) | (gen_copy[3] >> (64 - ROT_S3));
        low    = res & 64'hffff_ffff;
        v      = real'(low) / 4294967295.0 * 1000000.0;
        c.bits   = $realtobits(v);
        c.row    = FIELD_W'(p / MATRIX_DIM);
        c.column = FIELD_W'(p % MATRIX_DIM);
        c.last   = (p == CELLS - 1);
        next_pos = (p + 1 >= CELLS) ? 0 : p + 1;
        return c;
    endfunction

    task automatic report(input string what, input bit [63:0] want, input bit [63:0] got);
        errors++;
        $display("mismatch %s: expected %h got %h at %0t", what, want, got, $realtime);
    endtask

    function automatic cell_exp_t zero_cell(input int p);
        cell_exp_t c;
        c.bits   = '0;
        c.row    = FIELD_W'(p / MATRIX_DIM);
        c.column = FIELD_W'(p % MATRIX_DIM);
        c.last   = 1'b0;
        return c;
    endfunction

    // input and output monitor
    always @(posedge clk)
    begin
        cell_exp_t  c;
        typed_exp_t ty;
        if (rst_n)
        begin
            cycles++;
            if (cycles > LIMIT)
            begin
                $display("[FAIL] regression broken");
                $finish;
            end
            if (push && !full)
            begin
                c  = next_cell(restart);
                ty = typed_q.pop_front();
                cell_q.push_back(ty.known ? ty.want : c);
            end
            if (pop && !empty)
            begin
                if (cell_q.size() == 0)
                    report("unexpected word", '0, cell_bits);
                else
                begin
                    c = cell_q.pop_front();
                    if (cell_bits !== c.bits)    report("cell_bits", c.bits, cell_bits);
                    if (row !== c.row)           report("row", c.row, row);
                    if (column !== c.column)     report("column", c.column, column);
                    if (last_cell !== c.last)    report("last_cell", c.last, last_cell);
                end
            end
        end
    end

    // result side: random stall per word
    initial
    begin
        int stall;
        pop = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = no_stall ? 0 : $urandom_range(0, 15);
            repeat (stall)
            begin
                @(negedge clk);
                pop <= 1'b0;
            end
            @(negedge clk);
            pop <= 1'b1;
            do @(posedge clk); while (empty);
        end
    end

    task automatic send(input bit rs, input typed_exp_t ty, input int gap);
        repeat (gap)
        begin
            @(negedge clk);
            push <= 1'b0;
        end
        @(negedge clk);
        typed_q.push_back(ty);
        push    <= 1'b1;
        restart <= rs;
        do @(posedge clk); while (full);
    endtask

    task automatic drain();
        @(negedge clk);
        push <= 1'b0;
        wait (cell_q.size() == 0);
        repeat (10) @(posedge clk);
    endtask

    task automatic write_reg(input int idx, input bit [63:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_IDX_W'(idx);
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        if (idx < SEED_WORDS)
            seed_copy[idx] = data;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic bit [63:0] rand_word();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            default: return {$urandom(), $urandom()};
        endcase
    endfunction

    task automatic load_seeds(input int set);
        for (int i = 0; i < SEED_WORDS; i++)
        begin
            case (set)
                0: write_reg(i, '0);
                1: write_reg(i, '1);
                2: write_reg(i, (i == 0) ? 64'd1 : 64'd0);
                3: write_reg(i, 64'h0123_4567_89ab_cdef ^ {32'h0, 32'(i)} << (i * 8));
                default: write_reg(i, rand_word());
            endcase
        end
    endtask

    dir_row_t   dir_rows [$];
    typed_exp_t none;

    initial
    begin
        int        set_now;
        int        seg_len;
        bit        rs;
        dir_row_t  d;
        rst_n     = 1'b0;
        push      = 1'b0;
        restart   = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        errors    = 0;
        cycles    = 0;
        no_stall  = 1'b0;
        next_pos  = 0;
        none.known = 1'b0;
        none.want  = zero_cell(0);
        foreach (seed_copy[i])
        begin
            seed_copy[i] = '0;
            gen_copy[i]  = '0;
        end
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // zero state straight out of reset, then restart from an all-zero seed
        dir_rows.push_back('{0, 1'b0, '{1'b1, zero_cell(0)}});
        dir_rows.push_back('{0, 1'b0, '{1'b1, zero_cell(1)}});
        dir_rows.push_back('{0, 1'b0, '{1'b1, zero_cell(2)}});
        dir_rows.push_back('{0, 1'b1, '{1'b1, zero_cell(0)}});
        dir_rows.push_back('{0, 1'b0, '{1'b1, zero_cell(1)}});
        dir_rows.push_back('{1, 1'b1, none});
        dir_rows.push_back('{1, 1'b0, none});
        dir_rows.push_back('{1, 1'b0, none});
        dir_rows.push_back('{1, 1'b1, none});
        dir_rows.push_back('{1, 1'b0, none});
        dir_rows.push_back('{2, 1'b1, none});
        dir_rows.push_back('{2, 1'b0, none});
        dir_rows.push_back('{2, 1'b0, none});
        dir_rows.push_back('{3, 1'b0, none});
        dir_rows.push_back('{3, 1'b1, none});
        dir_rows.push_back('{3, 1'b0, none});
        dir_rows.push_back('{3, 1'b1, none});
        dir_rows.push_back('{3, 1'b0, none});

        set_now = 0;
        foreach (dir_rows[i])
        begin
            d = dir_rows[i];
            if (d.seed_set != set_now)
            begin
                drain();
                load_seeds(d.seed_set);
                set_now = d.seed_set;
            end
            send(d.restart, d.typed, $urandom_range(0, 3));
        end

        // random segments; the first runs well past one full matrix without stalls
        for (int seg = 0; seg < 12; seg++)
        begin
            drain();
            load_seeds(4);
            if ($urandom_range(0, 2) == 0)
                write_reg($urandom_range(SEED_WORDS, (1 << CFG_IDX_W) - 1), rand_word());
            no_stall = (seg == 0);
            seg_len  = (seg == 0) ? CELLS + 150 : $urandom_range(40, 160);
            for (int n = 0; n < seg_len; n++)
            begin
                rs = (n == 0 && seg != 0) ? 1'b1 : ($urandom_range(0, 99) == 0);
                if (seg == 0)
                    rs = (n == 0);
                send(rs, none, (seg == 0) ? 0 : $urandom_range(0, 15));
                // mid-run seed writes must not disturb the generator
                if (seg == 1 && n == 60)
                begin
                    drain();
                    load_seeds(4);
                end
            end
        end
        no_stall = 1'b0;
        drain();

        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
